// File: src/ssp_pkg.sv
// Shared types and constants for the sprite screen projection block.
// Used by the front end, the item queue and the back-end pipeline.
package ssp_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_PLAYER_X      = 3'd0;
   localparam logic [2:0] REG_PLAYER_Y      = 3'd1;
   localparam logic [2:0] REG_DIR_X         = 3'd2;
   localparam logic [2:0] REG_DIR_Y         = 3'd3;
   localparam logic [2:0] REG_PLANE_X       = 3'd4;
   localparam logic [2:0] REG_PLANE_Y       = 3'd5;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

   // Reset values of the configuration registers.
   localparam logic [15:0] RST_DIR_X         = 16'd16384;
   localparam logic [15:0] RST_PLANE_Y       = 16'd10813;
   localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;

   // Item queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Saturation limits.
   localparam logic signed [23:0] DEPTH_MAX  = 24'sh7FFFFF;
   localparam logic signed [23:0] DEPTH_MIN  = -24'sh800000;
   localparam logic signed [15:0] CENTER_MAX = 16'sh7FFF;
   localparam logic signed [15:0] CENTER_MIN = -16'sh8000;
   localparam logic [15:0]        SIZE_MAX   = 16'hFFFF;

   // Sprite offset from the player, signed Q9.8.
   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
   } item_type;

   // Camera configuration as seen by the back end.
   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] plane_x;
      logic signed [15:0] plane_y;
      logic [12:0]        screen_width;
      logic [12:0]        screen_height;
      logic signed [32:0] det;
   } cfg_type;

   // Queue status seen by the front end.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: src/ssp_front.sv
// Front end: configuration registers, camera determinant and item intake.
// Depends on ssp_pkg; feeds sprite offsets into the item queue.
module ssp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // sprite_x[15:0], sprite_y[31:16]
   input  logic                      csr_wen,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   input  ssp_pkg::queue_status_type q_status,
   output logic                      q_push,
   output ssp_pkg::item_type         q_item,
   output ssp_pkg::cfg_type          cfg
);

   logic [15:0]        player_x_ff, player_y_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [12:0]        screen_width_ff, screen_height_ff;
   logic signed [32:0] det_ff, det_in;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff      <= '0;
         player_y_ff      <= '0;
         dir_x_ff         <= ssp_pkg::RST_DIR_X;
         dir_y_ff         <= '0;
         plane_x_ff       <= '0;
         plane_y_ff       <= ssp_pkg::RST_PLANE_Y;
         screen_width_ff  <= ssp_pkg::RST_SCREEN_WIDTH;
         screen_height_ff <= ssp_pkg::RST_SCREEN_HEIGHT;
      end else if (csr_wen) begin
         unique case (csr_index)
            ssp_pkg::REG_PLAYER_X:      player_x_ff      <= csr_wdata;
            ssp_pkg::REG_PLAYER_Y:      player_y_ff      <= csr_wdata;
            ssp_pkg::REG_DIR_X:         dir_x_ff         <= csr_wdata;
            ssp_pkg::REG_DIR_Y:         dir_y_ff         <= csr_wdata;
            ssp_pkg::REG_PLANE_X:       plane_x_ff       <= csr_wdata;
            ssp_pkg::REG_PLANE_Y:       plane_y_ff       <= csr_wdata;
            ssp_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata[12:0];
            ssp_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Camera determinant, recomputed every cycle from the registers.
   assign det_in = 33'(plane_x_ff) * 33'(dir_y_ff) - 33'(dir_x_ff) * 33'(plane_y_ff);

   always_ff @(posedge clock) begin
      det_ff <= det_in;
   end

   assign cfg.dir_x         = dir_x_ff;
   assign cfg.dir_y         = dir_y_ff;
   assign cfg.plane_x       = plane_x_ff;
   assign cfg.plane_y       = plane_y_ff;
   assign cfg.screen_width  = screen_width_ff;
   assign cfg.screen_height = screen_height_ff;
   assign cfg.det           = det_ff;

   // Accept an item whenever the queue has room and store its offset.
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && !q_status.full;
   assign q_item.dx  = $signed({1'b0, req_tdata[15:0]}) - $signed({1'b0, player_x_ff});
   assign q_item.dy  = $signed({1'b0, req_tdata[31:16]}) - $signed({1'b0, player_y_ff});

endmodule

// File: src/ssp_queue.sv
// Short item queue that decouples the front end from the back-end pipeline.
// Depends on ssp_pkg for the item type and depth.
module ssp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ssp_pkg::item_type         push_item,
   input  logic                      pop,
   output ssp_pkg::queue_status_type status,
   output ssp_pkg::item_type         head_item
);

   ssp_pkg::item_type                entry_ff [0:ssp_pkg::QUEUE_DEPTH-1];
   logic [ssp_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [ssp_pkg::QCNT_W-1:0]       count_ff;
   logic                             do_push, do_pop;

   assign status.full  = (count_ff == ssp_pkg::QCNT_W'(ssp_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = entry_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/ssp_back.sv
// Back-end pipeline: camera transform, depth, center and size dividers, bounds.
// Depends on ssp_pkg; pulls items from the queue and drives the result channel.
module ssp_back (
   input  logic              clock,
   input  logic              reset,
   input  ssp_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  ssp_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [119:0]      rsp_tdata
);

   typedef struct packed {
      logic det_zero;
      logic d_neg;
      logic d_ovf;
      logic c_neg;
      logic c_ovf;
   } dctx_type;

   typedef struct packed {
      logic               ok;
      logic signed [23:0] depth;
      logic signed [15:0] center;
      logic               s_ovf;
   } sctx_type;

   logic adv;

   // The whole pipeline moves when the output register is free or being taken.
   assign adv   = !rsp_tvalid || rsp_tready;
   assign q_pop = adv && !q_empty;

   // Stage 1: camera-space numerators.
   logic               s1_v_ff;
   logic signed [33:0] nx_ff, ny_ff, nx_in, ny_in;

   assign nx_in = 34'(cfg.dir_y) * 34'(q_item.dx) - 34'(cfg.dir_x) * 34'(q_item.dy);
   assign ny_in = 34'(cfg.plane_x) * 34'(q_item.dy) - 34'(cfg.plane_y) * 34'(q_item.dx);

   // Stage 2: center product and magnitudes.
   logic               s2_v_ff;
   logic signed [47:0] cprod_ff, cprod_in;
   logic signed [34:0] sum_in;
   logic signed [12:0] half_w;
   logic [33:0]        ny_abs_ff;
   logic               ny_neg_ff;
   logic [32:0]        det_abs_ff;
   logic               det_neg_ff, det_zero_ff;

   assign sum_in   = 35'(nx_ff) + 35'(ny_ff);
   assign half_w   = $signed({1'b0, cfg.screen_width[12:1]});
   assign cprod_in = 48'(half_w) * 48'(sum_in);

   // Stage 3 is index 0 of the divider arrays.
   logic [56:0] drem_ff [0:24];
   logic [32:0] dden_ff [0:24];
   logic [23:0] dq_ff   [0:24];
   logic [49:0] crem_ff [0:24];
   logic [33:0] cden_ff [0:24];
   logic [15:0] cq_ff   [0:24];
   dctx_type    dctx_ff [0:24];
   logic        dv_ff   [0:24];

   logic        c_neg_in;
   logic [46:0] c_abs_in;

   assign c_neg_in = cprod_ff[47];
   assign c_abs_in = c_neg_in ? 47'(-cprod_ff) : 47'(cprod_ff);

   // Size divider arrays, index 0 holds the saturated depth and center.
   logic [39:0] srem_ff [0:16];
   logic [23:0] sden_ff [0:16];
   logic [15:0] sq_ff   [0:16];
   sctx_type    sctx_ff [0:16];
   logic        sv_ff   [0:16];

   // Depth and center saturation after the first dividers.
   logic               d_big, c_big_pos, c_big_neg;
   logic [23:0]        dq_last;
   logic [15:0]        cq_last;
   logic signed [23:0] depth_sat;
   logic signed [15:0] center_sat;
   logic [23:0]        depth_abs;
   logic [24:0]        size_num;
   dctx_type           dctx_last;

   assign dq_last   = dq_ff[24];
   assign cq_last   = cq_ff[24];
   assign dctx_last = dctx_ff[24];
   assign d_big     = dctx_last.d_ovf || dq_last[23];
   assign c_big_pos = dctx_last.c_ovf || cq_last[15];
   assign c_big_neg = dctx_last.c_ovf || (cq_last[15] && (cq_last[14:0] != '0));
   assign size_num  = {cfg.screen_height, 12'b0};

   always_comb begin
      if (dctx_last.d_neg) begin
         depth_sat = d_big ? ssp_pkg::DEPTH_MIN : -$signed(dq_last);
         depth_abs = d_big ? 24'h800000 : dq_last;
      end else begin
         depth_sat = d_big ? ssp_pkg::DEPTH_MAX : $signed(dq_last);
         depth_abs = d_big ? 24'h7FFFFF : dq_last;
      end
      if (dctx_last.c_neg) begin
         center_sat = c_big_neg ? ssp_pkg::CENTER_MIN : -$signed(cq_last);
      end else begin
         center_sat = c_big_pos ? ssp_pkg::CENTER_MAX : $signed(cq_last);
      end
   end

   // Front stages of the pipeline, then the depth and center dividers.
   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff       <= nx_in;
         ny_ff       <= ny_in;
         cprod_ff    <= cprod_in;
         ny_neg_ff   <= ny_ff[33];
         ny_abs_ff   <= ny_ff[33] ? 34'(-ny_ff) : 34'(ny_ff);
         det_neg_ff  <= cfg.det[32];
         det_abs_ff  <= cfg.det[32] ? 33'(-cfg.det) : 33'(cfg.det);
         det_zero_ff <= (cfg.det == '0);

         // Divider setup and overflow checks.
         drem_ff[0]          <= {5'b0, ny_abs_ff, 18'b0};
         dden_ff[0]          <= det_abs_ff;
         dq_ff[0]            <= '0;
         crem_ff[0]          <= {3'b0, c_abs_in};
         cden_ff[0]          <= ny_abs_ff;
         cq_ff[0]            <= '0;
         dctx_ff[0].det_zero <= det_zero_ff;
         dctx_ff[0].d_neg    <= ny_neg_ff ^ det_neg_ff;
         dctx_ff[0].d_ovf    <= {6'b0, ny_abs_ff, 18'b0} >= {1'b0, det_abs_ff, 24'b0};
         dctx_ff[0].c_neg    <= c_neg_in ^ ny_neg_ff;
         dctx_ff[0].c_ovf    <= {3'b0, c_abs_in} >= {ny_abs_ff, 16'b0};

         // Depth and center dividers, one quotient bit per stage.
         for (int k = 1; k <= 24; k++) begin
            dden_ff[k] <= dden_ff[k-1];
            cden_ff[k] <= cden_ff[k-1];
            dctx_ff[k] <= dctx_ff[k-1];
            if (drem_ff[k-1] >= (57'(dden_ff[k-1]) << (24 - k))) begin
               drem_ff[k] <= drem_ff[k-1] - (57'(dden_ff[k-1]) << (24 - k));
               dq_ff[k]   <= {dq_ff[k-1][22:0], 1'b1};
            end else begin
               drem_ff[k] <= drem_ff[k-1];
               dq_ff[k]   <= {dq_ff[k-1][22:0], 1'b0};
            end
            // The center quotient has 16 bits; later stages only carry it.
            if (k > 16) begin
               crem_ff[k] <= crem_ff[k-1];
               cq_ff[k]   <= cq_ff[k-1];
            end else if (crem_ff[k-1] >= (50'(cden_ff[k-1]) << (16 - k))) begin
               crem_ff[k] <= crem_ff[k-1] - (50'(cden_ff[k-1]) << (16 - k));
               cq_ff[k]   <= {cq_ff[k-1][14:0], 1'b1};
            end else begin
               crem_ff[k] <= crem_ff[k-1];
               cq_ff[k]   <= {cq_ff[k-1][14:0], 1'b0};
            end
         end
      end
   end

   // Saturation and size divider setup, then the size divider itself.
   always_ff @(posedge clock) begin
      if (adv) begin
         srem_ff[0]        <= {15'b0, size_num};
         sden_ff[0]        <= depth_abs;
         sq_ff[0]          <= '0;
         sctx_ff[0].ok     <= !dctx_last.det_zero && (depth_sat != '0);
         sctx_ff[0].depth  <= depth_sat;
         sctx_ff[0].center <= center_sat;
         sctx_ff[0].s_ovf  <= {15'b0, size_num} >= {depth_abs, 16'b0};
         for (int k = 1; k <= 16; k++) begin
            sden_ff[k] <= sden_ff[k-1];
            sctx_ff[k] <= sctx_ff[k-1];
            if (srem_ff[k-1] >= (40'(sden_ff[k-1]) << (16 - k))) begin
               srem_ff[k] <= srem_ff[k-1] - (40'(sden_ff[k-1]) << (16 - k));
               sq_ff[k]   <= {sq_ff[k-1][14:0], 1'b1};
            end else begin
               srem_ff[k] <= srem_ff[k-1];
               sq_ff[k]   <= {sq_ff[k-1][14:0], 1'b0};
            end
         end
      end
   end

   // Drawing bounds from the size and center.
   sctx_type           sctx_last;
   logic [15:0]        size_val;
   logic [14:0]        half_s;
   logic [11:0]        half_h;
   logic signed [16:0] rs_w;
   logic [16:0]        re_w;
   logic signed [17:0] cs_w, ce_w;
   logic [14:0]        rs_val, cs_val;
   logic [15:0]        re_val, ce_val;
   logic [119:0]       tdata_in;

   assign sctx_last = sctx_ff[16];
   assign size_val  = sctx_last.s_ovf ? ssp_pkg::SIZE_MAX : sq_ff[16];
   assign half_s    = size_val[15:1];
   assign half_h    = cfg.screen_height[12:1];
   assign rs_w      = $signed({5'b0, half_h}) - $signed({2'b0, half_s});
   assign re_w      = {5'b0, half_h} + {2'b0, half_s};
   assign cs_w      = 18'(sctx_last.center) - $signed({3'b0, half_s});
   assign ce_w      = 18'(sctx_last.center) + $signed({3'b0, half_s});
   assign rs_val    = rs_w[16] ? '0 : rs_w[14:0];
   assign re_val    = (re_w >= {4'b0, cfg.screen_height}) ?
                      16'({3'b0, cfg.screen_height}) - 16'd1 : re_w[15:0];
   assign cs_val    = cs_w[17] ? '0 : cs_w[14:0];
   assign ce_val    = (ce_w >= $signed({5'b0, cfg.screen_width})) ?
                      16'({3'b0, cfg.screen_width}) - 16'd1 : ce_w[15:0];

   always_comb begin
      if (sctx_last.ok) begin
         tdata_in = {ce_val, cs_val, re_val, rs_val, size_val, sctx_last.center,
                     sctx_last.depth, !sctx_last.depth[23], 1'b1};
      end else begin
         tdata_in = '0;
      end
   end

   // Output register.
   logic [119:0] rsp_tdata_ff;
   logic         rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= tdata_in;
      end
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int k = 0; k <= 24; k++) begin
            dv_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= 16; k++) begin
            sv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_v_ff       <= q_pop;
         s2_v_ff       <= s1_v_ff;
         dv_ff[0]      <= s2_v_ff;
         sv_ff[0]      <= dv_ff[24];
         rsp_tvalid_ff <= sv_ff[16];
         for (int k = 1; k <= 24; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         for (int k = 1; k <= 16; k++) begin
            sv_ff[k] <= sv_ff[k-1];
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: src/sprite_screen_projection.sv
// Sprite screen projection, top level.
// Depends on ssp_pkg, ssp_front, ssp_queue and ssp_back.
//
// Usage: write the player position, view direction, camera plane and screen
// size through the csr_ port while no item is in flight. Each item on the
// req_ channel is one sprite map position; one result item leaves on the
// rsp_ channel for every accepted item, in order.
// An accepted item passes the queue entry, two transform stages, a divider
// setup stage, a 24-stage depth divider (center divider alongside), one
// saturation stage, a 16-stage size divider and the output register.
// Throughput is one item per cycle unless the output stalls (rsp_tvalid high,
// rsp_tready low); each depth and size divider stage resolves one quotient
// bit. Reset clears the configuration to its defaults and empties the queue
// and pipeline. On a stall the pipeline freezes, the four-entry queue keeps
// taking items, and req_tready drops when it is full.
module sprite_screen_projection (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // sprite_x, sprite_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // valid_res, in_front, depth, center_column,
                                     // sprite_size, row_start, row_end,
                                     // column_start, column_end
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   ssp_pkg::queue_status_type q_status;
   ssp_pkg::item_type         q_push_item, q_head_item;
   ssp_pkg::cfg_type          cfg;
   logic                      q_push, q_pop;

   // Intake and configuration.
   ssp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (q_push_item),
      .cfg        (cfg)
   );

   // Decoupling queue.
   ssp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .status    (q_status),
      .head_item (q_head_item)
   );

   // Projection pipeline.
   ssp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_status.empty),
      .q_item     (q_head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
